FILE: rtl/rtcprp_pkg.sv
// ----------------------------------------------------------------------------
// rtcprp_pkg: shared types and constants of the report parser
// Payload structs, status codes, register indexes and queue sizing.
// ----------------------------------------------------------------------------
package rtcprp_pkg;

   // result status codes
   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_BAD_VERSION  = 3'd1;
   localparam logic [2:0] STATUS_UNKNOWN_TYPE = 3'd2;
   localparam logic [2:0] STATUS_BAD_LENGTH   = 3'd3;
   localparam logic [2:0] STATUS_TRUNCATED    = 3'd4;

   // report kinds
   localparam logic KIND_RECEIVER = 1'b0;
   localparam logic KIND_SENDER   = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENDER_TYPE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECEIVER_TYPE = 1'd1;

   localparam logic [7:0] SENDER_TYPE_RESET   = 8'd200;
   localparam logic [7:0] RECEIVER_TYPE_RESET = 8'd201;

   // header checks
   localparam logic [1:0]  RTP_VERSION    = 2'd2;
   localparam logic [15:0] SENDER_LENGTH   = 16'd6;
   localparam logic [15:0] RECEIVER_LENGTH = 16'd7;

   // byte positions
   localparam int POS_W = 6;
   localparam logic [POS_W-1:0] POS_VERSION   = 6'd0;
   localparam logic [POS_W-1:0] POS_TYPE      = 6'd1;
   localparam logic [POS_W-1:0] POS_LENGTH    = 6'd3;
   localparam logic [POS_W-1:0] SENDER_LAST   = 6'd27;
   localparam logic [POS_W-1:0] RECEIVER_LAST = 6'd31;

   localparam int FIELD_COUNT = 7;
   localparam int FIELD_IDX_W = 3;

   // command queue between front and back
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_datagram;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               report_kind;
      logic [31:0]        reporter_ssrc;
      logic [31:0]        body_word_one;
      logic [31:0]        body_word_two;
      logic [31:0]        body_word_three;
      logic [31:0]        body_word_four;
      logic [31:0]        body_word_five;
      logic [7:0]         loss_fraction;
      logic signed [23:0] packets_lost;
      logic [31:0]        middle_ntp_stamp;
   } rsp_type;

   // one classified byte handed from front to back
   typedef struct packed {
      logic [7:0]             data_byte;
      logic                   shift;
      logic                   store;
      logic [FIELD_IDX_W-1:0] idx;
      logic                   emit;
      logic [2:0]             status;
      logic                   kind;
   } cmd_type;

endpackage

FILE: rtl/rtcprp_front.sv
// ----------------------------------------------------------------------------
// rtcprp_front: byte classifier
// Tracks byte position, checks header fields and decides result status.
// ----------------------------------------------------------------------------
module rtcprp_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  rtcprp_pkg::req_type               req_data,
   input  logic                              fifo_full,
   input  logic                              csr_write,
   input  logic [rtcprp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                        csr_data,
   output logic                              push,
   output rtcprp_pkg::cmd_type               cmd
);

   logic [rtcprp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                         kind_ff, kind_in;
   logic                         discard_ff, discard_in;
   logic [7:0]                   prev_ff;
   logic [7:0]                   sender_type_ff, receiver_type_ff;

   logic       accept;
   logic       has_status;
   logic [2:0] status;
   logic       store;
   logic [7:0] b;
   logic       eod;

   assign accept = req_valid && !fifo_full;
   assign b      = req_data.data_byte;
   assign eod    = req_data.end_of_datagram;

   always_comb begin
      has_status = 1'b0;
      status     = rtcprp_pkg::STATUS_OK;
      kind_in    = kind_ff;
      store      = 1'b0;
      if (pos_ff == rtcprp_pkg::POS_VERSION) begin
         if (b[7:6] != rtcprp_pkg::RTP_VERSION) begin
            has_status = 1'b1;
            status     = rtcprp_pkg::STATUS_BAD_VERSION;
         end
      end else if (pos_ff == rtcprp_pkg::POS_TYPE) begin
         if (b == receiver_type_ff) begin
            kind_in = rtcprp_pkg::KIND_RECEIVER;
         end else if (b == sender_type_ff) begin
            kind_in = rtcprp_pkg::KIND_SENDER;
         end else begin
            has_status = 1'b1;
            status     = rtcprp_pkg::STATUS_UNKNOWN_TYPE;
         end
      end else if (pos_ff == rtcprp_pkg::POS_LENGTH) begin
         if ({prev_ff, b} != (kind_ff ? rtcprp_pkg::SENDER_LENGTH
                                      : rtcprp_pkg::RECEIVER_LENGTH)) begin
            has_status = 1'b1;
            status     = rtcprp_pkg::STATUS_BAD_LENGTH;
         end
      end else if (pos_ff[1:0] == 2'b11) begin
         store = 1'b1;
         if (pos_ff == (kind_ff ? rtcprp_pkg::SENDER_LAST : rtcprp_pkg::RECEIVER_LAST)) begin
            has_status = 1'b1;
            status     = rtcprp_pkg::STATUS_OK;
         end
      end
      if (!has_status && eod) begin
         has_status = 1'b1;
         status     = rtcprp_pkg::STATUS_TRUNCATED;
      end
   end

   // position and discard tracking
   always_comb begin
      pos_in     = pos_ff;
      discard_in = discard_ff;
      if (discard_ff) begin
         if (eod) begin
            discard_in = 1'b0;
            pos_in     = '0;
         end
      end else if (has_status) begin
         pos_in     = '0;
         discard_in = !eod;
      end else begin
         pos_in = pos_ff + 1'b1;
      end
   end

   assign push = accept && !discard_ff && (has_status || (pos_ff > rtcprp_pkg::POS_TYPE));

   always_comb begin
      cmd.data_byte = b;
      cmd.shift     = (pos_ff > rtcprp_pkg::POS_TYPE);
      cmd.store     = store;
      // word index of body field: (pos - 4) / 4
      cmd.idx       = rtcprp_pkg::FIELD_IDX_W'(pos_ff[rtcprp_pkg::POS_W-1:2] - 1'b1);
      cmd.emit      = has_status;
      cmd.status    = status;
      cmd.kind      = kind_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= '0;
         kind_ff          <= rtcprp_pkg::KIND_RECEIVER;
         discard_ff       <= 1'b0;
         sender_type_ff   <= rtcprp_pkg::SENDER_TYPE_RESET;
         receiver_type_ff <= rtcprp_pkg::RECEIVER_TYPE_RESET;
      end else begin
         if (accept) begin
            pos_ff     <= pos_in;
            discard_ff <= discard_in;
            if (!discard_ff) begin
               kind_ff <= kind_in;
            end
         end
         if (csr_write) begin
            case (csr_index)
               rtcprp_pkg::CSR_SENDER_TYPE:   sender_type_ff   <= csr_data;
               rtcprp_pkg::CSR_RECEIVER_TYPE: receiver_type_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_ff <= b;
      end
   end

endmodule

FILE: rtl/rtcprp_fifo.sv
// ----------------------------------------------------------------------------
// rtcprp_fifo: command queue
// Small flip-flop queue that decouples the classifier from the assembler.
// ----------------------------------------------------------------------------
module rtcprp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rtcprp_pkg::cmd_type push_data,
   input  logic                pop,
   output rtcprp_pkg::cmd_type head,
   output logic                empty,
   output logic                full
);

   rtcprp_pkg::cmd_type              mem_ff [rtcprp_pkg::FIFO_DEPTH];
   logic [rtcprp_pkg::FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [rtcprp_pkg::FIFO_CW-1:0]   count_ff;

   localparam logic [rtcprp_pkg::FIFO_AW-1:0] LAST_PTR =
      rtcprp_pkg::FIFO_AW'(rtcprp_pkg::FIFO_DEPTH - 1);
   localparam logic [rtcprp_pkg::FIFO_CW-1:0] FULL_COUNT =
      rtcprp_pkg::FIFO_CW'(rtcprp_pkg::FIFO_DEPTH);

   assign empty = (count_ff == '0);
   assign full  = (count_ff == FULL_COUNT);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/rtcprp_back.sv
// ----------------------------------------------------------------------------
// rtcprp_back: word assembler and result register
// Builds big-endian body words, stores fields and forms the result.
// ----------------------------------------------------------------------------
module rtcprp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                fifo_empty,
   input  rtcprp_pkg::cmd_type head,
   input  logic                rsp_stall,
   output logic                pop,
   output logic                rsp_valid,
   output rtcprp_pkg::rsp_type rsp_data
);

   logic [23:0]         shift_ff;
   logic [31:0]         field_ff [rtcprp_pkg::FIELD_COUNT];
   logic                rsp_valid_ff;
   rtcprp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [31:0] word;
   logic [31:0] fv [rtcprp_pkg::FIELD_COUNT];
   logic        slot_free;

   assign word      = {shift_ff, head.data_byte};
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop       = !fifo_empty && (!head.emit || slot_free);

   // field view with the word completed this cycle forwarded
   always_comb begin
      for (int k = 0; k < rtcprp_pkg::FIELD_COUNT; k++) begin
         fv[k] = (head.store && (head.idx == rtcprp_pkg::FIELD_IDX_W'(k))) ? word : field_ff[k];
      end
   end

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in.status = head.status;
      if (head.status == rtcprp_pkg::STATUS_OK) begin
         rsp_data_in.report_kind   = head.kind;
         rsp_data_in.reporter_ssrc = fv[0];
         rsp_data_in.body_word_one = fv[1];
         if (head.kind == rtcprp_pkg::KIND_SENDER) begin
            rsp_data_in.body_word_two    = fv[2];
            rsp_data_in.body_word_three  = fv[3];
            rsp_data_in.body_word_four   = fv[4];
            rsp_data_in.body_word_five   = fv[5];
            rsp_data_in.middle_ntp_stamp = {fv[1][15:0], fv[2][31:16]};
         end else begin
            rsp_data_in.body_word_two   = fv[3];
            rsp_data_in.body_word_three = fv[4];
            rsp_data_in.body_word_four  = fv[5];
            rsp_data_in.body_word_five  = fv[6];
            rsp_data_in.loss_fraction   = fv[2][31:24];
            rsp_data_in.packets_lost    = fv[2][23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop && head.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.shift) begin
         shift_ff <= word[23:0];
      end
      if (pop && head.store) begin
         field_ff[head.idx] <= word;
      end
      if (pop && head.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/rtcp_report_parser.sv
// ----------------------------------------------------------------------------
// rtcp_report_parser: sender / receiver report parser
// Parses the first report of a byte-serial datagram into one result.
// ----------------------------------------------------------------------------
// a result passes from its deciding byte through the command queue and the result register
// throughput: one byte per cycle, sustained, while rsp_stall stays low
// the command queue holds two bytes, so the front runs on while a result waits
// reset: synchronous, active high; clears position, discard and queue state,
// empties the result register and loads type registers with 200 and 201
module rtcp_report_parser (
   input  logic                              clock,
   input  logic                              reset,
   // byte input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rtcprp_pkg::req_type               req_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rtcprp_pkg::rsp_type               rsp_data,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rtcprp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                        csr_data
);

   logic                fifo_full;
   logic                fifo_empty;
   logic                push;
   logic                pop;
   rtcprp_pkg::cmd_type push_cmd;
   rtcprp_pkg::cmd_type head_cmd;

   // configuration writes are always accepted
   assign csr_ready = 1'b1;

   // input stalls only when the command queue is full
   assign req_stall = fifo_full;

   // front: position counter, header checks, status decision per transaction
   rtcprp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .fifo_full (fifo_full),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push      (push),
      .cmd       (push_cmd)
   );

   // queue: lets the front keep taking bytes while a result is held
   rtcprp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .head      (head_cmd),
      .empty     (fifo_empty),
      .full      (fifo_full)
   );

   // back: word shifter, field registers and the output register
   rtcprp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .head       (head_cmd),
      .rsp_stall  (rsp_stall),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: rtl/rtcprp_checker.sv
// ----------------------------------------------------------------------------
// rtcprp_checker: port-level checks of the report parser
// Watches result transactions and reset behavior at the top-level ports.
// ----------------------------------------------------------------------------
module rtcprp_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input rtcprp_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // error results carry only the status
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != rtcprp_pkg::STATUS_OK) |->
         rsp_data.report_kind == 1'b0 && rsp_data.reporter_ssrc == '0 &&
         rsp_data.body_word_one == '0 && rsp_data.body_word_five == '0 &&
         rsp_data.middle_ntp_stamp == '0 && rsp_data.packets_lost == '0)
      else $error("error result with payload");

   // sender and receiver fields do not mix
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == rtcprp_pkg::STATUS_OK) |->
         (rsp_data.report_kind == rtcprp_pkg::KIND_SENDER) ?
            (rsp_data.loss_fraction == '0 && rsp_data.packets_lost == '0) :
            (rsp_data.middle_ntp_stamp == '0))
      else $error("report fields of the wrong kind");

   // status stays within its code set
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == rtcprp_pkg::STATUS_OK ||
                     rsp_data.status == rtcprp_pkg::STATUS_BAD_VERSION ||
                     rsp_data.status == rtcprp_pkg::STATUS_UNKNOWN_TYPE ||
                     rsp_data.status == rtcprp_pkg::STATUS_BAD_LENGTH ||
                     rsp_data.status == rtcprp_pkg::STATUS_TRUNCATED))
      else $error("status code out of range");

endmodule

bind rtcp_report_parser rtcprp_checker u_rtcprp_checker (.*);
